// ===== rtl/core/epf_pkg.sv =====
// Shared types, line codes and helpers for the escaped packet framer.
`timescale 1ns / 1ps
`default_nettype none

package epf_pkg;

	localparam logic [7:0] START_BYTE = 8'h2B; // '+'
	localparam logic [7:0] END_BYTE   = 8'h2D; // '-'
	localparam logic [7:0] ESC_BYTE   = 8'h23; // '#'
	localparam logic [7:0] STAR_BYTE  = 8'h2A; // '*'
	localparam logic [7:0] CHECK_BASE = 8'hFF;

	// Command queue between classifier and emitter.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Emission steps, one bit each, in line order.
	localparam int NSTEP      = 6;
	localparam int STEP_START = 0;
	localparam int STEP_ESC_D = 1;
	localparam int STEP_DATA  = 2;
	localparam int STEP_ESC_C = 3;
	localparam int STEP_CHECK = 4;
	localparam int STEP_END   = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_first;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_end;
	} out_word_t;

	// Classified item: what the emitter has to put on the line.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] check_byte;
		logic       has_start;
		logic       esc_data;
		logic       has_tail;
		logic       esc_check;
	} cmd_t;

	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = (b == STAR_BYTE) || (b == START_BYTE) ||
			(b == END_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/escaped_packet_framer.sv =====
// Top level of the escaped packet framer: classifier, command queue, emitter.
// A word is written into the queue, then leaves through the output register.
// Throughput: one input word per cycle into a 4-entry queue while not full;
// the emitter puts one line byte per cycle unless out_stall holds, and a word
// makes 1 to 6 line bytes. Reset: arst_n clears checksum, queue and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module escaped_packet_framer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire epf_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output epf_pkg::out_word_t      out_word
);
	import epf_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// Front: take words while the queue has room, fold the checksum and
	// mark which escapes, start and tail bytes each word needs.
	epf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// Queue: hold classified words so the line side can stall on its own.
	epf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: advance through the head word's line bytes, one per free
	// output slot, and drop the word after its last byte.
	epf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// ===== rtl/core/epf_front.sv =====
// Front end: accepts input words, folds the checksum and classifies escapes.
`timescale 1ns / 1ps
`default_nettype none

module epf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire epf_pkg::in_word_t in_word,
	input  wire logic             q_full,
	output logic                  q_push,
	output epf_pkg::cmd_t         q_cmd
);
	import epf_pkg::*;

	logic [7:0] running_xor_q;
	logic [7:0] xor_base;
	logic [7:0] xor_next;
	logic [7:0] check;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// A first flag restarts the sum from this byte.
	assign xor_base = in_word.is_first ? 8'h00 : running_xor_q;
	assign xor_next = xor_base ^ in_word.data_byte;
	assign check    = CHECK_BASE - xor_next;

	always_comb begin
		q_cmd.data_byte  = in_word.data_byte;
		q_cmd.check_byte = check;
		q_cmd.has_start  = in_word.is_first;
		q_cmd.esc_data   = needs_escape(in_word.data_byte);
		q_cmd.has_tail   = in_word.is_last;
		q_cmd.esc_check  = in_word.is_last && needs_escape(check);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_xor_q <= 8'h00;
		end else if (q_push) begin
			running_xor_q <= in_word.is_last ? 8'h00 : xor_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/epf_queue.sv =====
// Small command queue that decouples the classifier from the emitter.
`timescale 1ns / 1ps
`default_nettype none

module epf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire epf_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output epf_pkg::cmd_t      head_cmd,
	output logic               full,
	output logic               empty
);
	import epf_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/epf_back.sv =====
// Back end: walks one command through its line bytes into the output register.
`timescale 1ns / 1ps
`default_nettype none

module epf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire epf_pkg::cmd_t head_cmd,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output epf_pkg::out_word_t out_word
);
	import epf_pkg::*;

	logic [NSTEP-1:0] done_q;
	logic [NSTEP-1:0] needed;
	logic [NSTEP-1:0] pending;
	logic [NSTEP-1:0] cur;
	logic             is_final;
	logic             load;
	logic [7:0]       line_byte;
	logic             out_valid_q;
	out_word_t        out_word_q;

	always_comb begin
		needed             = '0;
		needed[STEP_START] = head_cmd.has_start;
		needed[STEP_ESC_D] = head_cmd.esc_data;
		needed[STEP_DATA]  = 1'b1;
		needed[STEP_ESC_C] = head_cmd.esc_check;
		needed[STEP_CHECK] = head_cmd.has_tail;
		needed[STEP_END]   = head_cmd.has_tail;
	end

	// Lowest pending step goes out next; it is the last one if nothing else remains.
	assign pending  = needed & ~done_q;
	assign cur      = pending & (~pending + 1'b1);
	assign is_final = (pending == cur);

	always_comb begin
		line_byte = head_cmd.data_byte;
		case (1'b1)
			cur[STEP_START]: line_byte = START_BYTE;
			cur[STEP_ESC_D]: line_byte = ESC_BYTE;
			cur[STEP_DATA]:  line_byte = head_cmd.data_byte;
			cur[STEP_ESC_C]: line_byte = ESC_BYTE;
			cur[STEP_CHECK]: line_byte = head_cmd.check_byte;
			cur[STEP_END]:   line_byte = END_BYTE;
			default:         line_byte = head_cmd.data_byte;
		endcase
	end

	assign load      = !out_valid_q || !out_stall;
	assign q_pop     = load && !q_empty && is_final;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_word_q.line_byte <= line_byte;
			out_word_q.run_end   <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				done_q <= is_final ? '0 : (done_q | cur);
			end
		end
	end

endmodule

`default_nettype wire
